// ===== design/tga_pkg.sv =====
// Shared types and constants for the run-length coded pixel decoder.
package tga_pkg;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic [1:0] REG_FOUR_BYTE_PIXELS = 2'd0;
  localparam logic [1:0] REG_RUN_LENGTH_CODED = 2'd1;
  localparam logic [1:0] REG_PIXEL_TOTAL      = 2'd2;

  localparam logic [7:0] RUN_BIAS    = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RAW    = 3'b010,
    PH_RUN    = 3'b100
  } phase_t;

  typedef struct packed {
    logic        four_byte_pixels;
    logic        run_length_coded;
    logic [31:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [7:0]  repeat_count;
    logic        last_of_image;
    logic        clipped;
  } result_t;

endpackage

// ===== design/tga_cfg.sv =====
// Configuration register bank with an APB-style access port.
module tga_cfg
  import tga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready,
  output cfg_t                cfg
);

  logic        four_byte_r;
  logic        rle_r;
  logic [31:0] total_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_byte_r <= 1'b0;
      rle_r       <= 1'b0;
      total_r     <= 32'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FOUR_BYTE_PIXELS: four_byte_r <= cfg_pwdata[0];
        REG_RUN_LENGTH_CODED: rle_r       <= cfg_pwdata[0];
        REG_PIXEL_TOTAL:      total_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FOUR_BYTE_PIXELS: cfg_prdata = {31'd0, four_byte_r};
      REG_RUN_LENGTH_CODED: cfg_prdata = {31'd0, rle_r};
      REG_PIXEL_TOTAL:      cfg_prdata = total_r;
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg.four_byte_pixels = four_byte_r;
  assign cfg.run_length_coded = rle_r;
  assign cfg.pixel_total      = total_r;

endmodule

// ===== design/tga_core.sv =====
// Per-byte decode state and result formation.
module tga_core
  import tga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       image_start,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt, eff_phase;
  logic [7:0]  raw_left_r, raw_left_nxt, eff_raw;
  logic [7:0]  run_len_r, run_len_nxt, eff_run;
  logic [1:0]  bip_r, bip_nxt, eff_bip, last_idx;
  logic [23:0] colour_r, colour_nxt, eff_colour;
  logic [31:0] left_r, left_nxt, eff_left;
  logic        done_r, done_nxt, eff_done;
  logic [7:0]  count_raw;
  logic        over, finish;
  logic        produce;

  always_comb begin
    eff_phase  = image_start ? PH_HEADER : phase_r;
    eff_raw    = image_start ? 8'd0 : raw_left_r;
    eff_run    = image_start ? 8'd0 : run_len_r;
    eff_bip    = image_start ? 2'd0 : bip_r;
    eff_colour = image_start ? 24'd0 : colour_r;
    eff_left   = image_start ? cfg.pixel_total : left_r;
    eff_done   = image_start ? (cfg.pixel_total == 32'd0) : done_r;

    phase_nxt    = eff_phase;
    raw_left_nxt = eff_raw;
    run_len_nxt  = eff_run;
    bip_nxt      = eff_bip;
    colour_nxt   = eff_colour;
    left_nxt     = eff_left;
    done_nxt     = eff_done;
    produce      = 1'b0;
    res          = '0;
    last_idx     = cfg.four_byte_pixels ? 2'd3 : 2'd2;
    count_raw    = (cfg.run_length_coded && eff_phase == PH_RUN) ? eff_run : 8'd1;
    over         = {24'd0, count_raw} > eff_left;
    finish       = {24'd0, count_raw} >= eff_left;

    if (!eff_done) begin
      if (cfg.run_length_coded && eff_phase == PH_HEADER) begin
        if (!data_byte[7]) begin
          raw_left_nxt = {1'b0, data_byte[6:0]} + 8'd1;
          phase_nxt    = PH_RAW;
        end else begin
          run_len_nxt = data_byte - RUN_BIAS;
          phase_nxt   = PH_RUN;
        end
        bip_nxt = 2'd0;
      end else begin
        case (eff_bip)
          2'd0:    colour_nxt[7:0]   = data_byte;
          2'd1:    colour_nxt[15:8]  = data_byte;
          2'd2:    colour_nxt[23:16] = data_byte;
          default: ;
        endcase
        if (eff_bip < last_idx) begin
          bip_nxt = eff_bip + 2'd1;
        end else begin
          bip_nxt           = 2'd0;
          produce           = 1'b1;
          res.pixel_word    = {cfg.four_byte_pixels ? data_byte : ALPHA_OPAQUE, colour_nxt};
          res.repeat_count  = over ? eff_left[7:0] : count_raw;
          res.last_of_image = finish;
          res.clipped       = over;
          left_nxt          = finish ? 32'd0 : eff_left - {24'd0, count_raw};
          if (!cfg.run_length_coded) begin
            phase_nxt = PH_HEADER;
          end else if (eff_phase == PH_RAW) begin
            if (eff_raw <= 8'd1) begin
              raw_left_nxt = 8'd0;
              phase_nxt    = PH_HEADER;
            end else begin
              raw_left_nxt = eff_raw - 8'd1;
              if (finish) begin
                res.clipped = 1'b1;
              end
            end
          end else begin
            phase_nxt = PH_HEADER;
          end
          if (finish) begin
            done_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign res_valid = accept & produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      raw_left_r <= '0;
      run_len_r  <= '0;
      bip_r      <= '0;
      colour_r   <= '0;
      left_r     <= '0;
      done_r     <= 1'b1;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      raw_left_r <= raw_left_nxt;
      run_len_r  <= run_len_nxt;
      bip_r      <= bip_nxt;
      colour_r   <= colour_nxt;
      left_r     <= left_nxt;
      done_r     <= done_nxt;
    end
  end

  a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> left_r != 32'd0)
    else $error("decoder active with no pixels left");

  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last_of_image |=> done_r && left_r == 32'd0)
    else $error("image not closed after its last item");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !image_start |-> !res_valid)
    else $error("result produced while waiting for a start");

endmodule

// ===== design/tga_skid.sv =====
// Output register with a skid stage so input ready does not depend on output ready.
module tga_skid
  import tga_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    drain;

  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign drain     = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push) begin
        if (out_valid_r && !out_ready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (drain) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end else if (drain && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output is empty");

  a_skid_promotes: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && !skid_valid_r)
    else $error("skid item not moved to the output");

endmodule

// ===== design/tga_rle_pixel_decoder.sv =====
// Top level of the run-length coded true-colour pixel decoder.
//
//   Group   Dir   Payload
//   in_     in    tdata = data_byte, tuser = image_start
//   out_    out   tdata = pixel_word, repeat_count; tlast = last_of_image; tuser = clipped
//   cfg_    in    registers four_byte_pixels, run_length_coded, pixel_total
//
// One byte is taken per cycle while input ready is high; the result of the byte
// completing a pixel is registered. Per-byte state update is one pass of logic.
// Reset is synchronous and leaves the decoder waiting for a start byte.
// A second output entry takes a result that completes while the output is
// stalled; input ready is low for as long as that entry is occupied.
module tga_rle_pixel_decoder
  import tga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tuser,   // [0] image_start
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // [31:0] pixel_word, [39:32] repeat_count
  output logic                out_tlast,
  output logic                out_tuser,  // [0] clipped
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = in_tvalid & in_tready;

  tga_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tga_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .accept      (accept),
    .data_byte   (in_tdata),
    .image_start (in_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  tga_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.repeat_count, out_res.pixel_word};
  assign out_tlast = out_res.last_of_image;
  assign out_tuser = out_res.clipped;

endmodule
